// ----- rtl/core/scl_pkg.sv -----
// scl_pkg: shared types, codes and character constants of the serial command line parser
// used by the top level, the scan unit and the checker of the parser; no dependencies
`timescale 1ns / 1ps

package scl_pkg;

  // result status codes
  localparam logic [2:0] ST_WAIT    = 3'd0;
  localparam logic [2:0] ST_READY   = 3'd1;
  localparam logic [2:0] ST_BADCHAR = 3'd2;
  localparam logic [2:0] ST_LONG    = 3'd3;
  localparam logic [2:0] ST_FRAME   = 3'd4;
  localparam logic [2:0] ST_VALUE   = 3'd5;
  localparam logic [2:0] ST_UNKNOWN = 3'd6;

  // command codes
  localparam logic [1:0] CMD_PWM  = 2'd0;
  localparam logic [1:0] CMD_LED  = 2'd1;
  localparam logic [1:0] CMD_RATE = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_PWM_MAX  = 2'd0;
  localparam logic [1:0] CFG_LED_MAX  = 2'd1;
  localparam logic [1:0] CFG_RATE_MIN = 2'd2;
  localparam logic [1:0] CFG_RATE_MAX = 2'd3;

  localparam logic [31:0] PWM_MAX_RST  = 32'd100;
  localparam logic [31:0] LED_MAX_RST  = 32'd1;
  localparam logic [31:0] RATE_MIN_RST = 32'd1;
  localparam logic [31:0] RATE_MAX_RST = 32'd1000;

  localparam logic [7:0] CH_AT = 8'h40;
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_A  = 8'h41;
  localparam logic [7:0] CH_Z  = 8'h5A;

  typedef struct packed {
    logic clear;
    logic chr_valid;
    logic first;
  } scl_scan_ctl_t;

  typedef struct packed {
    logic        frame_bad;
    logic        unknown;
    logic        value_bad;
    logic [1:0]  cmd;
    logic [31:0] number;
  } scl_scan_res_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  command;
    logic [31:0] number;
    logic        in_range;
  } scl_result_t;

  function automatic logic byte_ok(logic [7:0] c);
    return (c >= CH_A && c <= CH_Z) || (c >= CH_0 && c <= CH_9) || c == CH_AT || c == CH_EQ;
  endfunction

  // letters of the command words, indexed by position in the name
  function automatic logic [6:0] word_char(logic [1:0] cmd, logic [1:0] idx);
    logic [6:0] ch;
    ch = 7'h00;
    unique case (cmd)
      CMD_PWM: begin
        unique case (idx)
          2'd0:    ch = 7'h50; // P
          2'd1:    ch = 7'h57; // W
          2'd2:    ch = 7'h4D; // M
          default: ch = 7'h00;
        endcase
      end
      CMD_LED: begin
        unique case (idx)
          2'd0:    ch = 7'h4C; // L
          2'd1:    ch = 7'h45; // E
          2'd2:    ch = 7'h44; // D
          default: ch = 7'h00;
        endcase
      end
      CMD_RATE: begin
        unique case (idx)
          2'd0: ch = 7'h52; // R
          2'd1: ch = 7'h41; // A
          2'd2: ch = 7'h54; // T
          2'd3: ch = 7'h45; // E
        endcase
      end
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage

// ----- rtl/core/serial_command_line_parser.sv -----
// serial_command_line_parser: top level with byte classification, line walk sequencer,
// limit registers and output staging; depends on scl_pkg, scl_line_mem, scl_scan
`timescale 1ns / 1ps

// Collects received bytes into lines of the form @NAME=DIGITS and answers every accepted
// byte with exactly one transaction. A byte other than a newline that starts a line check
// is settled in the cycle it is accepted and its answer is staged in the pend register;
// the next byte is taken once that answer has moved on to the output register. A newline
// ending a line walks the line memory one entry per cycle through its single read port
// in S_READ, then passes S_DRAIN and S_JUDGE; its answer is staged in the pend register
// and the next byte is taken once it has moved on to the output register. A finished
// answer waits in the output register while the next byte is taken and processed. The
// line memory needs no clearing pass after reset; the user must write limits through
// the cfg port only while the block is idle, which the block itself does not enforce.
module serial_command_line_parser #(
  parameter int LINE_MAX   = 16,
  parameter int NAME_MAX   = 7,
  parameter int DIGITS_MAX = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [1:0]  command,
  output logic [31:0] number,
  output logic        in_range,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  import scl_pkg::*;

  localparam int AW = $clog2(LINE_MAX);
  localparam int CW = $clog2(LINE_MAX + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_JUDGE
  } state_t;

  state_t        state;
  logic [CW-1:0] fill;
  logic          skip;
  logic [CW-1:0] fill_next;
  logic          skip_next;
  logic [CW-1:0] scan_len;
  logic [AW-1:0] rd_ptr;
  logic          rd_valid;
  logic          rd_first;
  logic          pend_valid;
  scl_result_t   pend;
  scl_result_t   out_res;
  scl_result_t   imm_res;
  scl_result_t   judge_res;
  logic          accept;
  logic          store;
  logic          start_scan;
  logic [31:0]   pwm_max;
  logic [31:0]   led_max;
  logic [31:0]   rate_min;
  logic [31:0]   rate_max;
  logic [6:0]    mem_rdata;
  scl_scan_ctl_t scan_ctl;
  scl_scan_res_t scan_res;

  assign in_stall = (state != S_IDLE) || pend_valid;
  assign accept   = in_valid && !in_stall;

  // per-byte decisions for everything but the line check
  always_comb begin
    imm_res    = '{status: ST_WAIT, command: CMD_NONE, number: 32'd0, in_range: 1'b0};
    store      = 1'b0;
    start_scan = 1'b0;
    fill_next  = fill;
    skip_next  = skip;
    priority if (skip) begin
      if (rx_byte == CH_LF) begin
        fill_next = '0;
        skip_next = 1'b0;
      end
    end else if (rx_byte == CH_CR) begin
      fill_next = fill;
    end else if (rx_byte == CH_LF) begin
      fill_next = '0;
      if (fill == '0) begin
        imm_res.status = ST_FRAME;
      end else begin
        start_scan = 1'b1;
      end
    end else if (!byte_ok(rx_byte)) begin
      fill_next      = '0;
      skip_next      = 1'b1;
      imm_res.status = ST_BADCHAR;
    end else if (fill >= CW'(LINE_MAX)) begin
      fill_next      = '0;
      skip_next      = 1'b1;
      imm_res.status = ST_LONG;
    end else begin
      store     = 1'b1;
      fill_next = fill + 1'b1;
    end
  end

  always_comb begin
    judge_res = '{status: ST_READY, command: scan_res.cmd, number: scan_res.number,
                  in_range: 1'b0};
    unique case (scan_res.cmd)
      CMD_PWM:  judge_res.in_range = scan_res.number <= pwm_max;
      CMD_LED:  judge_res.in_range = scan_res.number <= led_max;
      default:  judge_res.in_range = (scan_res.number >= rate_min)
                                     && (scan_res.number <= rate_max);
    endcase
    priority if (scan_res.frame_bad) begin
      judge_res = '{status: ST_FRAME, command: CMD_NONE, number: 32'd0, in_range: 1'b0};
    end else if (scan_res.unknown) begin
      judge_res = '{status: ST_UNKNOWN, command: CMD_NONE, number: 32'd0, in_range: 1'b0};
    end else if (scan_res.value_bad) begin
      judge_res = '{status: ST_VALUE, command: CMD_NONE, number: 32'd0, in_range: 1'b0};
    end else begin
      judge_res.status = ST_READY;
    end
  end

  assign scan_ctl.clear     = accept && start_scan;
  assign scan_ctl.chr_valid = rd_valid;
  assign scan_ctl.first     = rd_first;

  scl_line_mem #(
    .DEPTH (LINE_MAX),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (accept && store),
    .waddr (fill[AW-1:0]),
    .wdata (rx_byte[6:0]),
    .re    (state == S_READ),
    .raddr (rd_ptr),
    .rdata (mem_rdata)
  );

  scl_scan #(
    .LINE_MAX   (LINE_MAX),
    .NAME_MAX   (NAME_MAX),
    .DIGITS_MAX (DIGITS_MAX)
  ) u_scan (
    .clk (clk),
    .ctl (scan_ctl),
    .chr (mem_rdata),
    .res (scan_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      skip       <= 1'b0;
      rd_valid   <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      pwm_max    <= PWM_MAX_RST;
      led_max    <= LED_MAX_RST;
      rate_min   <= RATE_MIN_RST;
      rate_max   <= RATE_MAX_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PWM_MAX:  pwm_max  <= cfg_data;
          CFG_LED_MAX:  led_max  <= cfg_data;
          CFG_RATE_MIN: rate_min <= cfg_data;
          CFG_RATE_MAX: rate_max <= cfg_data;
        endcase
      end

      // staged answer moves to the output register when that one is free or taken
      if (pend_valid && (!out_valid || !out_stall)) begin
        out_valid  <= 1'b1;
        out_res    <= pend;
        pend_valid <= 1'b0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            fill <= fill_next;
            skip <= skip_next;
            if (start_scan) begin
              state    <= S_READ;
              rd_ptr   <= '0;
              scan_len <= fill;
            end else begin
              pend_valid <= 1'b1;
              pend       <= imm_res;
            end
          end
        end
        S_READ: begin
          rd_valid <= 1'b1;
          rd_first <= (rd_ptr == '0);
          rd_ptr   <= rd_ptr + 1'b1;
          if (CW'(rd_ptr) + CW'(1) == scan_len) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // last character is taken by the scan unit at this edge
          rd_valid <= 1'b0;
          state    <= S_JUDGE;
        end
        S_JUDGE: begin
          pend_valid <= 1'b1;
          pend       <= judge_res;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign status   = out_res.status;
  assign command  = out_res.command;
  assign number   = out_res.number;
  assign in_range = out_res.in_range;

endmodule

// ----- rtl/core/scl_line_mem.sv -----
// scl_line_mem: line character store, one write port and one registered read port
// no package dependencies
`timescale 1ns / 1ps

module scl_line_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [6:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [6:0]    rdata
);

  logic [6:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/scl_scan.sv -----
// scl_scan: walks the stored line one character a cycle and builds the frame,
// name and value verdicts plus the decimal value; depends on scl_pkg
`timescale 1ns / 1ps

module scl_scan #(
  parameter int LINE_MAX   = 16,
  parameter int NAME_MAX   = 7,
  parameter int DIGITS_MAX = 10
) (
  input  logic                  clk,
  input  scl_pkg::scl_scan_ctl_t ctl,
  input  logic [6:0]            chr,
  output scl_pkg::scl_scan_res_t res
);

  import scl_pkg::*;

  localparam int CW = $clog2(LINE_MAX + 1);

  logic          bad_frame;
  logic [1:0]    eq_cnt;
  logic          in_value;
  logic [CW-1:0] name_len;
  logic [CW-1:0] val_len;
  logic          m_pwm;
  logic          m_led;
  logic          m_rate;
  logic          digit_bad;
  logic          ovf;
  logic [31:0]   acc;
  logic [35:0]   acc_next;
  logic          is_digit;
  logic          hit_pwm;
  logic          hit_led;
  logic          hit_rate;

  assign is_digit = (chr >= CH_0[6:0]) && (chr <= CH_9[6:0]);
  // times ten as two shifts and an add
  assign acc_next = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {32'b0, chr[3:0]};

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      bad_frame <= 1'b0;
      eq_cnt    <= 2'd0;
      in_value  <= 1'b0;
      name_len  <= '0;
      val_len   <= '0;
      m_pwm     <= 1'b1;
      m_led     <= 1'b1;
      m_rate    <= 1'b1;
      digit_bad <= 1'b0;
      ovf       <= 1'b0;
      acc       <= 32'd0;
    end else if (ctl.chr_valid) begin
      priority if (ctl.first) begin
        if (chr != CH_AT[6:0]) begin
          bad_frame <= 1'b1;
        end
      end else if (chr == CH_AT[6:0]) begin
        bad_frame <= 1'b1;
      end else if (chr == CH_EQ[6:0]) begin
        if (eq_cnt != 2'd2) begin
          eq_cnt <= eq_cnt + 2'd1;
        end
        in_value <= 1'b1;
      end else if (!in_value) begin
        m_pwm    <= m_pwm && (name_len < CW'(3)) && (chr == word_char(CMD_PWM, name_len[1:0]));
        m_led    <= m_led && (name_len < CW'(3)) && (chr == word_char(CMD_LED, name_len[1:0]));
        m_rate   <= m_rate && (name_len < CW'(4))
                    && (chr == word_char(CMD_RATE, name_len[1:0]));
        name_len <= name_len + 1'b1;
      end else begin
        val_len <= val_len + 1'b1;
        if (!is_digit) begin
          digit_bad <= 1'b1;
        end else if (!ovf) begin
          if (acc_next[35:32] != 4'd0) begin
            ovf <= 1'b1;
          end else begin
            acc <= acc_next[31:0];
          end
        end
      end
    end
  end

  assign hit_pwm  = m_pwm && (name_len == CW'(3));
  assign hit_led  = m_led && (name_len == CW'(3));
  assign hit_rate = m_rate && (name_len == CW'(4));

  always_comb begin
    res.frame_bad = bad_frame || (eq_cnt != 2'd1) || (name_len == '0) || (val_len == '0)
                    || (32'(name_len) > 32'(NAME_MAX)) || (32'(val_len) > 32'(DIGITS_MAX));
    res.unknown   = !(hit_pwm || hit_led || hit_rate);
    res.value_bad = digit_bad || ovf;
    res.number    = acc;
    priority if (hit_pwm) begin
      res.cmd = CMD_PWM;
    end else if (hit_led) begin
      res.cmd = CMD_LED;
    end else if (hit_rate) begin
      res.cmd = CMD_RATE;
    end else begin
      res.cmd = CMD_NONE;
    end
  end

endmodule

// ----- rtl/core/scl_checker.sv -----
// scl_checker: port-level checks of the serial command line parser, bound to its top level
// depends on scl_pkg
`timescale 1ns / 1ps

module scl_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [1:0]  command,
  input logic [31:0] number,
  input logic        in_range
);

  import scl_pkg::*;

  // an accepted byte closes the input; in_stall is checked high right after the accepting edge
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after an accepted transaction");

  a_no_payload_unless_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_READY |-> command == CMD_NONE && number == 32'd0 && !in_range)
    else $error("command or number set on a non-ready answer");

  a_ready_has_command: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_READY |-> command != CMD_NONE)
    else $error("ready answer without a command");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(command)
      && $stable(number) && $stable(in_range))
    else $error("stalled output transaction changed");

endmodule

bind serial_command_line_parser scl_checker u_scl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .command   (command),
  .number    (number),
  .in_range  (in_range)
);
